>>> rtl/core/ipdfe_pkg.sv
package ipdfe_pkg;

    // Field widths
    localparam int DUR_W  = 16;
    localparam int CMD_W  = 32;
    localparam int POS_W  = 7;
    localparam int FRM_W  = 2;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Symbol positions inside one 68-symbol frame
    localparam logic [POS_W-1:0] POS_HDR_MARK  = 7'd0;
    localparam logic [POS_W-1:0] POS_HDR_SPACE = 7'd1;
    localparam logic [POS_W-1:0] POS_FTR_MARK  = 7'd66;
    localparam logic [POS_W-1:0] POS_FTR_SPACE = 7'd67;
    localparam logic [POS_W-1:0] POS_FIRST_BIT = 7'd2;
    localparam logic [POS_W-1:0] FRAME_LEN     = 7'd68;
    localparam logic [FRM_W-1:0] FRM_FIRST     = 2'd0;
    localparam logic [FRM_W-1:0] FRM_INVERTED  = 2'd1;
    localparam logic [FRM_W-1:0] FRM_LAST      = 2'd2;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    // Status codes
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_IDLE = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_HDR_MARK  = 3'd0;
    localparam logic [2:0] REG_HDR_SPACE = 3'd1;
    localparam logic [2:0] REG_BIT_MARK  = 3'd2;
    localparam logic [2:0] REG_ONE_SPACE = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE = 3'd4;
    localparam logic [2:0] REG_FTR_MARK  = 3'd5;
    localparam logic [2:0] REG_FTR_SPACE = 3'd6;

    // Register reset values (microseconds)
    localparam logic [DUR_W-1:0] RST_HDR_MARK   = 16'd8341;
    localparam logic [DUR_W-1:0] RST_HDR_SPACE  = 16'd3541;
    localparam logic [DUR_W-1:0] RST_BIT_MARK   = 16'd555;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 16'd1600;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 16'd491;
    localparam logic [DUR_W-1:0] RST_FTR_MARK   = 16'd555;
    localparam logic [DUR_W-1:0] RST_FTR_SPACE  = 16'd21077;

    typedef struct packed {
        logic             action;
        logic [CMD_W-1:0] command;
    } t_in;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic             is_mark;
        logic             last;
        logic             status;
    } t_out;

    typedef struct packed {
        logic [DUR_W-1:0] header_mark_time;
        logic [DUR_W-1:0] header_space_time;
        logic [DUR_W-1:0] bit_mark_time;
        logic [DUR_W-1:0] one_space_time;
        logic [DUR_W-1:0] zero_space_time;
        logic [DUR_W-1:0] footer_mark_time;
        logic [DUR_W-1:0] footer_space_time;
    } t_cfg;

    // Sequencer state, exported for checking
    typedef struct packed {
        logic             active;
        logic [FRM_W-1:0] frame;
        logic [POS_W-1:0] pos;
    } t_seq_state;

endpackage

>>> rtl/core/ir_pulse_distance_frame_encoder_core.sv
// Each request passes the input register, then the result register, before its
// result is valid; either register can hold it while the receiver stalls.
// Throughput: one request per cycle while the receiver is ready; each request yields exactly one result.
// Rate is set by the combinational duration select between the two stages.
// Reset (i_rst_n low, synchronous): pipeline empty, sequence idle, timing
// registers back to their default microsecond values.
module ir_pulse_distance_frame_encoder_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipdfe_pkg::ADDR_W-1:0] paddr,
    input  logic [ipdfe_pkg::DATA_W-1:0] pwdata,
    output logic [ipdfe_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  ipdfe_pkg::t_in               i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output ipdfe_pkg::t_out              o_data
);
    import ipdfe_pkg::*;

    t_cfg       w_cfg;
    t_seq_state w_state;

    // Timing registers
    ipdfe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Duration sequencer
    ipdfe_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .o_state (w_state)
    );

    // Idle sequencer sits at the start of frame zero
    a_idle_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_state.active |-> (w_state.frame == FRM_FIRST) && (w_state.pos == POS_HDR_MARK))
        else $error("idle sequencer not at home position");

    // Position and frame stay in range
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_state.pos < FRAME_LEN) && (w_state.frame != 2'd3))
        else $error("sequencer position or frame out of range");

    // Last duration is the final footer mark of a live sequence
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.is_mark && (o_data.status == STAT_OK))
        else $error("last flag on a non-mark or idle result");

    // Idle results carry no duration
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.status == STAT_IDLE) |->
            (o_data.duration == '0) && !o_data.is_mark && !o_data.last)
        else $error("idle result carries data");

endmodule

>>> rtl/core/ipdfe_regs.sv
module ipdfe_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ipdfe_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipdfe_pkg::DATA_W-1:0]  pwdata,
    output logic [ipdfe_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    output ipdfe_pkg::t_cfg               o_cfg
);
    import ipdfe_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_idx;
    logic       w_wr;
    logic [DUR_W-1:0] w_rd;

    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register write, values truncated to 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark_time  <= RST_HDR_MARK;
            r_cfg.header_space_time <= RST_HDR_SPACE;
            r_cfg.bit_mark_time     <= RST_BIT_MARK;
            r_cfg.one_space_time    <= RST_ONE_SPACE;
            r_cfg.zero_space_time   <= RST_ZERO_SPACE;
            r_cfg.footer_mark_time  <= RST_FTR_MARK;
            r_cfg.footer_space_time <= RST_FTR_SPACE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_HDR_MARK:   r_cfg.header_mark_time  <= pwdata[DUR_W-1:0];
                REG_HDR_SPACE:  r_cfg.header_space_time <= pwdata[DUR_W-1:0];
                REG_BIT_MARK:   r_cfg.bit_mark_time     <= pwdata[DUR_W-1:0];
                REG_ONE_SPACE:  r_cfg.one_space_time    <= pwdata[DUR_W-1:0];
                REG_ZERO_SPACE: r_cfg.zero_space_time   <= pwdata[DUR_W-1:0];
                REG_FTR_MARK:   r_cfg.footer_mark_time  <= pwdata[DUR_W-1:0];
                REG_FTR_SPACE:  r_cfg.footer_space_time <= pwdata[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux; unmapped addresses read zero
    always_comb begin
        unique case (w_idx)
            REG_HDR_MARK:   w_rd = r_cfg.header_mark_time;
            REG_HDR_SPACE:  w_rd = r_cfg.header_space_time;
            REG_BIT_MARK:   w_rd = r_cfg.bit_mark_time;
            REG_ONE_SPACE:  w_rd = r_cfg.one_space_time;
            REG_ZERO_SPACE: w_rd = r_cfg.zero_space_time;
            REG_FTR_MARK:   w_rd = r_cfg.footer_mark_time;
            REG_FTR_SPACE:  w_rd = r_cfg.footer_space_time;
            default:        w_rd = '0;
        endcase
    end

    assign prdata = {{(DATA_W-DUR_W){1'b0}}, w_rd};

endmodule

>>> rtl/core/ipdfe_pipe.sv
module ipdfe_pipe (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ipdfe_pkg::t_cfg       i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ipdfe_pkg::t_in        i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ipdfe_pkg::t_out       o_data,
    output ipdfe_pkg::t_seq_state o_state
);
    import ipdfe_pkg::*;

    // Input stage
    logic       r_in_vld;
    t_in        r_in;
    // Result stage
    logic       r_out_vld;
    t_out       r_out;
    // Sequence state
    logic [CMD_W-1:0] r_cmd;
    t_seq_state       r_st;

    logic             w_adv;
    logic             w_start;
    logic [CMD_W-1:0] w_cmd;
    logic [FRM_W-1:0] w_frm;
    logic [POS_W-1:0] w_pos;
    logic             w_run;
    logic [CMD_W-1:0] w_word;
    logic [POS_W-1:0] w_bit_off;
    logic [4:0]       w_idx;
    logic             w_bit;
    logic             w_fin;
    logic [POS_W-1:0] w_pos_inc;
    t_out             n_out;
    t_seq_state       n_st;

    // Handshake: result stage moves when empty or drained
    assign w_adv   = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || w_adv;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign o_state = r_st;

    // Effective state for this request: start reloads, next continues
    assign w_start = (r_in.action == ACT_START);
    assign w_cmd   = w_start ? r_in.command : r_cmd;
    assign w_frm   = w_start ? FRM_FIRST : r_st.frame;
    assign w_pos   = w_start ? POS_HDR_MARK : r_st.pos;
    assign w_run   = w_start || r_st.active;

    // Data bit under test, MSB first, inverted in the middle frame
    assign w_word    = (w_frm == FRM_INVERTED) ? ~w_cmd : w_cmd;
    assign w_bit_off = w_pos - POS_FIRST_BIT;
    assign w_idx     = w_bit_off[5:1];
    assign w_bit     = w_word[5'd31 - w_idx];
    assign w_fin     = (w_frm == FRM_LAST) && (w_pos == POS_FTR_MARK);
    assign w_pos_inc = w_pos + 7'd1;

    // Duration select and state advance
    always_comb begin
        n_out = '0;
        n_st  = r_st;
        if (!w_run) begin
            n_out.status = STAT_IDLE;
        end else begin
            n_out.status  = STAT_OK;
            n_out.is_mark = !w_pos[0];
            n_out.last    = w_fin;
            if (w_pos == POS_HDR_MARK) begin
                n_out.duration = i_cfg.header_mark_time;
            end else if (w_pos == POS_HDR_SPACE) begin
                n_out.duration = i_cfg.header_space_time;
            end else if (w_pos == POS_FTR_MARK) begin
                n_out.duration = i_cfg.footer_mark_time;
            end else if (w_pos == POS_FTR_SPACE) begin
                n_out.duration = i_cfg.footer_space_time;
            end else if (!w_pos[0]) begin
                n_out.duration = i_cfg.bit_mark_time;
            end else if (w_bit) begin
                n_out.duration = i_cfg.one_space_time;
            end else begin
                n_out.duration = i_cfg.zero_space_time;
            end
            if (w_fin) begin
                n_st = '0;
            end else if (w_pos_inc >= FRAME_LEN) begin
                n_st.active = 1'b1;
                n_st.pos    = POS_HDR_MARK;
                n_st.frame  = w_frm + 2'd1;
            end else begin
                n_st.active = 1'b1;
                n_st.pos    = w_pos_inc;
                n_st.frame  = w_frm;
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
            r_cmd     <= '0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
                if (w_start) begin
                    r_cmd <= r_in.command;
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

endmodule

>>> tb/ir_pulse_distance_frame_encoder_core_tb.sv
module ir_pulse_distance_frame_encoder_core_tb;
    import ipdfe_pkg::*;

    localparam int          CLK_HALF    = 6;
    localparam int          ITEM_TARGET = 850;
    localparam int          PHASE_ITEMS = 170;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          SEQ_NEXTS   = 202;
    // Address past the last timing register, writes must be dropped
    localparam logic [2:0]  REG_UNUSED  = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                i_valid;
    logic                o_ready;
    t_in                 i_data;
    logic                o_valid;
    logic                i_ready;
    t_out                o_data;

    ir_pulse_distance_frame_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // Encoder state as the testbench sees it
    t_cfg             timing;
    logic [CMD_W-1:0] tx_cmd;
    logic [FRM_W-1:0] tx_frame;
    logic [POS_W-1:0] tx_pos;
    logic             tx_active;

    t_out pending_durations[$];
    int   fail_count;
    int   sent_count;
    int   burst_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Next duration of the running sequence; advances the encoder state
    function automatic t_out next_duration(input t_in req);
        t_out             r;
        logic [CMD_W-1:0] word;
        logic [POS_W-1:0] offs;
        logic             fin;
        r = '0;
        if (req.action == ACT_START) begin
            tx_cmd    = req.command;
            tx_frame  = FRM_FIRST;
            tx_pos    = POS_HDR_MARK;
            tx_active = 1'b1;
        end else if (!tx_active) begin
            r.status = STAT_IDLE;
            return r;
        end
        case (tx_pos)
            POS_HDR_MARK:  r.duration = timing.header_mark_time;
            POS_HDR_SPACE: r.duration = timing.header_space_time;
            POS_FTR_MARK:  r.duration = timing.footer_mark_time;
            POS_FTR_SPACE: r.duration = timing.footer_space_time;
            default: begin
                if (!tx_pos[0]) begin
                    r.duration = timing.bit_mark_time;
                end else begin
                    // Middle frame carries the complemented command
                    word = (tx_frame == FRM_INVERTED) ? ~tx_cmd : tx_cmd;
                    offs = (tx_pos - POS_FIRST_BIT) >> 1;
                    r.duration = word[CMD_W - 1 - offs[4:0]] ? timing.one_space_time
                                                             : timing.zero_space_time;
                end
            end
        endcase
        fin       = (tx_frame == FRM_LAST) && (tx_pos == POS_FTR_MARK);
        r.is_mark = ~tx_pos[0];
        r.last    = fin;
        r.status  = STAT_OK;
        // Step to the next symbol; third footer mark ends the sequence
        if (fin) begin
            tx_active = 1'b0;
            tx_frame  = FRM_FIRST;
            tx_pos    = POS_HDR_MARK;
        end else if (tx_pos == FRAME_LEN - 1) begin
            tx_pos   = POS_HDR_MARK;
            tx_frame = tx_frame + 1'b1;
        end else begin
            tx_pos = tx_pos + 1'b1;
        end
        return r;
    endfunction

    // Send one request; valid stays high until a gap between bursts or the caller idles the channel
    task automatic send_req(input logic act, input logic [CMD_W-1:0] cmd);
        t_in req;
        req.action  = act;
        req.command = cmd;
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        pending_durations.push_back(next_duration(req));
        sent_count++;
        // Sender bursts with random gaps between them
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Idle the request channel until every result is back
    task automatic wait_drained;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_durations.size() != 0);
    endtask

    // APB write: setup phase, access phase, then the bus idles
    task automatic write_reg(input logic [2:0] idx, input logic [DUR_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HDR_MARK:   timing.header_mark_time  = val;
            REG_HDR_SPACE:  timing.header_space_time = val;
            REG_BIT_MARK:   timing.bit_mark_time     = val;
            REG_ONE_SPACE:  timing.one_space_time    = val;
            REG_ZERO_SPACE: timing.zero_space_time   = val;
            REG_FTR_MARK:   timing.footer_mark_time  = val;
            REG_FTR_SPACE:  timing.footer_space_time = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic program_timing(input t_cfg c);
        write_reg(REG_HDR_MARK,   c.header_mark_time);
        write_reg(REG_HDR_SPACE,  c.header_space_time);
        write_reg(REG_BIT_MARK,   c.bit_mark_time);
        write_reg(REG_ONE_SPACE,  c.one_space_time);
        write_reg(REG_ZERO_SPACE, c.zero_space_time);
        write_reg(REG_FTR_MARK,   c.footer_mark_time);
        write_reg(REG_FTR_SPACE,  c.footer_space_time);
        write_reg(REG_UNUSED,     16'($urandom()));
    endtask

    // Fetch while nothing is running returns idle status
    task automatic test_idle_fetch;
        send_req(ACT_NEXT, $urandom());
        send_req(ACT_NEXT, $urandom());
    endtask

    // A start drops whatever sequence is running
    task automatic test_restart;
        send_req(ACT_START, 32'hFFFF_FFFF);
        repeat (4) send_req(ACT_NEXT, $urandom());
        send_req(ACT_START, 32'h0000_0000);
        repeat (3) send_req(ACT_NEXT, $urandom());
        send_req(ACT_START, 32'hA5C3_0F96);
        repeat (2) send_req(ACT_NEXT, $urandom());
    endtask

    // New timing takes effect on the very next duration of an active sequence
    task automatic test_config_mid_sequence;
        wait_drained();
        program_timing(t_cfg'({$urandom(), $urandom(), $urandom(), 16'($urandom())}));
        repeat (5) send_req(ACT_NEXT, $urandom());
    endtask

    // Mostly complete sequences with random commands, some cut short
    task automatic test_random_sequences;
        int   phase;
        int   next_phase_at;
        int   count;
        t_cfg c;
        phase         = 0;
        next_phase_at = sent_count;
        while (sent_count < ITEM_TARGET) begin
            if (sent_count >= next_phase_at) begin
                case (phase)
                    0:       c = '0;
                    1:       c = '1;
                    2:       c = {RST_HDR_MARK, RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
                                  RST_ZERO_SPACE, RST_FTR_MARK, RST_FTR_SPACE};
                    default: c = t_cfg'({$urandom(), $urandom(), $urandom(),
                                         16'($urandom())});
                endcase
                wait_drained();
                program_timing(c);
                phase++;
                next_phase_at = sent_count + PHASE_ITEMS;
            end
            case ($urandom_range(0, 9))
                0, 1: begin
                    // Broken sequence: restarted or left running
                    send_req(ACT_START, $urandom());
                    repeat ($urandom_range(1, 150)) send_req(ACT_NEXT, $urandom());
                end
                2: begin
                    // Noise
                    count = $urandom_range(1, 6);
                    repeat (count) send_req(logic'($urandom_range(0, 1)), $urandom());
                end
                default: begin
                    send_req(ACT_START, $urandom());
                    repeat (SEQ_NEXTS) send_req(ACT_NEXT, $urandom());
                    // Fetches past the end see the idle status
                    repeat ($urandom_range(0, 2)) send_req(ACT_NEXT, $urandom());
                end
            endcase
        end
    endtask

    // Receiver stalls on a rotating mask, reloaded whenever its count runs out
    initial begin : ready_pattern
        logic [7:0]  mask;
        int unsigned count;
        mask    = 8'hFF;
        count   = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (count == 0) begin
                count = 32;
                if ($urandom_range(0, 3) == 0) begin
                    mask = 8'hFF;
                end else begin
                    mask = 8'($urandom());
                end
            end
            i_ready <= mask[0];
            mask = {mask[0], mask[7:1]};
            count--;
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest outstanding prediction
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_durations.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h", $time, o_data);
                fail_count++;
            end else begin
                want = pending_durations.pop_front();
                check_field("duration", want.duration, o_data.duration);
                check_field("is_mark",  want.is_mark,  o_data.is_mark);
                check_field("last",     want.last,     o_data.last);
                check_field("status",   want.status,   o_data.status);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        fail_count = 0;
        sent_count = 0;
        burst_left = 0;
        timing     = {RST_HDR_MARK, RST_HDR_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
                      RST_ZERO_SPACE, RST_FTR_MARK, RST_FTR_SPACE};
        tx_cmd     = '0;
        tx_frame   = FRM_FIRST;
        tx_pos     = POS_HDR_MARK;
        tx_active  = 1'b0;
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_fetch();
        test_restart();
        test_config_mid_sequence();
        test_random_sequences();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> ir_pulse_distance_frame_encoder_core.f
rtl/core/ipdfe_pkg.sv
rtl/core/ipdfe_regs.sv
rtl/core/ipdfe_pipe.sv
rtl/core/ir_pulse_distance_frame_encoder_core.sv
tb/ir_pulse_distance_frame_encoder_core_tb.sv
